### rtl/sha256_pkg.sv
// SHA-256 package: round constants, initial hash values, helper functions and types.
`default_nettype none
package sha256_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenPos = 56;
   localparam logic [7:0] PadMark = 8'h80;

   typedef logic [31:0] word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAD,
      ST_ZERO,
      ST_LEN,
      ST_LOADW,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic init;
   } core_ctl_type;

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type hash_init(input logic [2:0] idx);
      word_type h;
      case (idx)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab;
         default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

### rtl/sha256_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module sha256_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(Depth)-1:0]  wr_addr,
   input  wire [Width-1:0]          wr_data,
   input  wire [$clog2(Depth)-1:0]  rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/sha256_core.sv
// SHA-256 round engine: message schedule window, one round per cycle while round_en is set, hash update.
`default_nettype none
module sha256_core (
   input  wire                        clock,
   input  wire                        reset,
   input  wire sha256_pkg::core_ctl_type ctl,
   input  wire                        w_load,
   input  wire  sha256_pkg::word_type w_in,
   input  wire                        round_en,
   input  wire  [5:0]                 round_idx,
   input  wire                        update,
   input  wire  [2:0]                 rd_idx,
   output sha256_pkg::word_type       hash_out
);
   import sha256_pkg::*;

   word_type hash_ff [8];
   word_type hash_in [8];
   word_type v_ff [8];
   word_type v_in [8];
   word_type w_ff [16];
   word_type w_in_arr [16];
   word_type w_new, s0, s1, t1, t2, w_cur;

   always_comb begin
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      w_cur = w_ff[0];
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_k(round_idx) + w_cur;
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      for (int i = 0; i < 16; i++) begin
         w_in_arr[i] = w_ff[i];
      end
      for (int i = 0; i < 8; i++) begin
         v_in[i] = v_ff[i];
         hash_in[i] = hash_ff[i];
      end
      if (w_load || round_en) begin
         for (int i = 0; i < 15; i++) begin
            w_in_arr[i] = w_ff[i+1];
         end
         w_in_arr[15] = w_load ? w_in : w_new;
      end
      if (ctl.start) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i] = hash_ff[i];
         end
      end else if (round_en) begin
         v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
      if (ctl.init) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_init(3'(i));
         end
      end else if (update) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= hash_init(3'(i));
         end
      end else begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= hash_in[i];
         end
      end
      for (int i = 0; i < 8; i++) begin
         v_ff[i] <= v_in[i];
      end
      for (int i = 0; i < 16; i++) begin
         w_ff[i] <= w_in_arr[i];
      end
   end

   assign hash_out = hash_ff[rd_idx];
endmodule
`default_nettype wire

### rtl/sha256_message_hash_unit.sv
// SHA-256 message hash unit top level: byte intake, padding sequencer, digest output.
// Takes one byte per transfer, if byte_present is set, into a 64-byte buffer RAM; a
// byte that fills the block starts its compression, and no byte is taken meanwhile.
// A full block is compressed by one shared round unit: it reads 16 schedule words from
// the RAM (4 bytes each, one byte a cycle), then runs 64 rounds at one per cycle and
// one update step. On a last transfer the sequencer writes padding into the RAM one
// byte a cycle, compresses one or two blocks and then presents the eight digest words,
// one per output transfer. No item is taken from that point until the last word leaves.
`default_nettype none
module sha256_message_hash_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] message_byte
   input  wire  [0:0]  req_tuser,   // [0] byte_present
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast
);
   import sha256_pkg::*;

   state_type state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [63:0] len_ff, len_in, total_ff, total_in;
   logic [6:0] cnt_ff, cnt_in;
   logic fin_ff, fin_in;       // compression belongs to finishing
   logic second_ff, second_in; // another block follows (padding or length)
   logic [23:0] acc_ff, acc_in;
   logic [2:0] oidx_ff, oidx_in;

   logic ram_we;
   logic [5:0] ram_wa, ram_ra;
   logic [7:0] ram_wd, ram_rd;
   logic w_load, round_en, update;
   core_ctl_type ctl;
   word_type hash_out;
   logic acc_req;

   sha256_ram #(.Width(8), .Depth(64)) u_buf (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd));

   sha256_core u_core (
      .clock(clock), .reset(reset), .ctl(ctl), .w_load(w_load), .w_in({acc_ff, ram_rd}),
      .round_en(round_en), .round_idx(cnt_ff[5:0]), .update(update), .rd_idx(oidx_ff),
      .hash_out(hash_out));

   assign acc_req = req_tvalid && req_tready;

   // next state and counters
   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      len_in = len_ff;
      total_in = total_ff;
      cnt_in = cnt_ff;
      fin_in = fin_ff;
      second_in = second_ff;
      acc_in = acc_ff;
      oidx_in = oidx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc_req) begin
               if (req_tuser[0]) begin
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     len_in = len_ff + 64'd512;
                     cnt_in = '0;
                     fin_in = 1'b0;
                     // padding block follows when this byte ends the message
                     second_in = req_tlast;
                     state_in = ST_LOADW;
                  end else if (req_tlast) begin
                     state_in = ST_PAD;
                  end
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // fill_ff points at the pad position
            total_in = len_ff + {55'd0, fill_ff, 3'd0};
            fin_in = 1'b1;
            second_in = (fill_ff >= 6'd56);
            cnt_in = {1'b0, fill_ff + 6'd1};
            if (fill_ff == 6'd63) begin
               cnt_in = '0;
               state_in = ST_LOADW;
            end else if (fill_ff == 6'd55) begin
               state_in = ST_LEN;
            end else begin
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            cnt_in = cnt_ff + 7'd1;
            if (second_ff ? (cnt_ff == 7'd63) : (cnt_ff == 7'd55)) begin
               cnt_in = second_ff ? 7'd0 : 7'd56;
               state_in = second_ff ? ST_LOADW : ST_LEN;
            end
         end
         ST_LEN: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               cnt_in = '0;
               state_in = ST_LOADW;
            end
         end
         ST_LOADW: begin
            // cnt 0..63 issues reads; the registered RAM data lands in the next cycle
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff != 7'd0) begin
               acc_in = {acc_ff[15:0], ram_rd};
            end
            if (cnt_ff == 7'd64) begin
               cnt_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!fin_ff) begin
               second_in = 1'b0;
               state_in = second_ff ? ST_PAD : ST_IDLE;
            end else if (second_ff) begin
               second_in = 1'b0;
               cnt_in = '0;
               state_in = ST_ZERO;
            end else begin
               oidx_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  fill_in = '0;
                  len_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_EMIT);
      rsp_tdata = hash_out;
      rsp_tuser = oidx_ff;
      rsp_tlast = (oidx_ff == 3'd7);
      ram_we = 1'b0;
      ram_wa = fill_ff;
      ram_wd = req_tdata;
      ram_ra = cnt_ff[5:0];
      w_load = 1'b0;
      round_en = 1'b0;
      update = 1'b0;
      ctl.start = 1'b0;
      ctl.init = 1'b0;
      case (state_ff)
         ST_IDLE: ram_we = acc_req && req_tuser[0];
         ST_PAD: begin
            ram_we = 1'b1;
            ram_wd = PadMark;
         end
         ST_ZERO: begin
            ram_we = 1'b1;
            ram_wa = cnt_ff[5:0];
            ram_wd = '0;
         end
         ST_LEN: begin
            ram_we = 1'b1;
            ram_wa = cnt_ff[5:0];
            ram_wd = total_ff[8*(7-cnt_ff[2:0]) +: 8];
         end
         ST_LOADW: begin
            w_load = (cnt_ff != 7'd0) && (cnt_ff[1:0] == 2'd0);
            ctl.start = (cnt_ff == 7'd64);
         end
         ST_ROUND: round_en = 1'b1;
         ST_UPDATE: update = 1'b1;
         ST_EMIT: ctl.init = rsp_tready && (oidx_ff == 3'd7);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         len_ff <= '0;
         cnt_ff <= '0;
         fin_ff <= 1'b0;
         second_ff <= 1'b0;
         oidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         len_ff <= len_in;
         cnt_ff <= cnt_in;
         fin_ff <= fin_in;
         second_ff <= second_in;
         oidx_ff <= oidx_in;
      end
      total_ff <= total_in;
      acc_ff <= acc_in;
   end
endmodule
`default_nettype wire
